// ----- rtl/core/bbdr_pkg.sv -----
// ----------------------------------------------------------------------------
// bbdr_pkg
// Shared types and constants for the bounding box depth range block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbdr_pkg;

    localparam int COORD_W   = 32;           // Q16.16 coordinate width
    localparam int UNIT_W    = 31;           // signed Q2.29 unit component
    localparam int UNIT_BITS = 29;           // fraction bits of unit vector
    localparam int IDX_W     = 3;            // config register index width

    localparam logic [30:0] NEAR_MIN     = 31'h0001_0000;  // 1.0
    localparam logic [30:0] NEAR_MAX     = 31'h7FFF_FFFF;
    localparam logic [31:0] DEF_MIN_DEP  = 32'h0001_0000;  // 1.0
    localparam logic [31:0] DEF_MAX_DEP  = 32'h000A_0000;  // 10.0
    localparam logic [31:0] EYE_Z_RESET  = 32'hFFFB_0000;  // -5.0

    // floor(x / 10) = (x * RECIP10) >> RECIP_SH, exact for x < 2^22
    localparam logic [21:0] RECIP10  = 22'd3355444;
    localparam int          RECIP_SH = 25;

    typedef enum logic [IDX_W-1:0] {
        REG_EYE_X    = 3'd0,
        REG_EYE_Y    = 3'd1,
        REG_EYE_Z    = 3'd2,
        REG_TARGET_X = 3'd3,
        REG_TARGET_Y = 3'd4,
        REG_TARGET_Z = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        NS_DIFF,
        NS_SHIFT,
        NS_SQ,
        NS_SQRT,
        NS_DIV,
        NS_DONE
    } norm_state_t;

    // direction unit status toward the datapath
    typedef struct packed {
        logic                     done;
        logic                     deg;
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
        logic signed [UNIT_W-1:0] uz;
    } norm_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/bbdr_norm.sv -----
// ----------------------------------------------------------------------------
// bbdr_norm
// Sequential unit normalizing target - eye to a Q2.29 unit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module bbdr_norm (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [2:0][bbdr_pkg::COORD_W-1:0]    eye_pos,
    input  wire logic [2:0][bbdr_pkg::COORD_W-1:0]    tgt_pos,
    output bbdr_pkg::norm_res_t                       res
);
    import bbdr_pkg::*;

    norm_state_t state_reg, state_next;

    logic [32:0]              mag_reg [3];
    logic                     neg_reg [3];
    logic                     deg_reg;
    logic [63:0]              sum_reg;
    logic [61:0]              sq_reg;
    logic [5:0]               cnt_reg;
    logic [1:0]               idx_reg;
    logic [63:0]              rad_reg;
    logic [63:0]              root_reg;
    logic [63:0]              bit_reg;
    logic [59:0]              dvd_reg;
    logic [31:0]              drem_reg;
    logic [29:0]              quo_reg;
    logic signed [UNIT_W-1:0] u_reg [3];

    logic [32:0] orv;
    logic [30:0] sq_src;
    logic [30:0] div_src;
    logic [32:0] dtrial;
    logic        qbit;
    logic [29:0] qfin;
    logic [63:0] sq_trial;

    assign orv = mag_reg[0] | mag_reg[1] | mag_reg[2];

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    sq_src = mag_reg[0][30:0];
            2'd1:    sq_src = mag_reg[1][30:0];
            default: sq_src = mag_reg[2][30:0];
        endcase
        case (idx_reg)
            2'd0:    div_src = mag_reg[1][30:0];
            default: div_src = mag_reg[2][30:0];
        endcase
        dtrial   = {drem_reg, dvd_reg[59]};
        qbit     = (dtrial >= {1'b0, root_reg[31:0]});
        qfin     = {quo_reg[28:0], qbit};
        sq_trial = root_reg + bit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NS_DIFF;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            NS_DIFF:  state_next = NS_SHIFT;
            NS_SHIFT: begin
                if (orv == 33'd0) begin
                    state_next = NS_DONE;
                end else if (!(orv[32] || orv[31]) && orv[30]) begin
                    state_next = NS_SQ;
                end
            end
            NS_SQ:    if (cnt_reg == 6'd3) state_next = NS_SQRT;
            NS_SQRT:  if (cnt_reg == 6'd31) state_next = NS_DIV;
            NS_DIV:   if (cnt_reg == 6'd59 && idx_reg == 2'd2) state_next = NS_DONE;
            NS_DONE:  state_next = NS_DONE;
            default:  state_next = NS_DIFF;
        endcase
        if (start) begin
            state_next = NS_DIFF;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            NS_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [32:0] d;
                    d = $signed({tgt_pos[i][31], tgt_pos[i]})
                      - $signed({eye_pos[i][31], eye_pos[i]});
                    neg_reg[i] <= d[32];
                    mag_reg[i] <= d[32] ? (33'd0 - $unsigned(d)) : $unsigned(d);
                end
                cnt_reg <= '0;
            end
            NS_SHIFT: begin
                deg_reg <= (orv == 33'd0);
                for (int i = 0; i < 3; i++) begin
                    if (orv[32] || orv[31]) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end else if (!orv[30]) begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            NS_SQ: begin
                sq_reg  <= 62'(sq_src) * 62'(sq_src);
                if (cnt_reg != 6'd0) begin
                    sum_reg <= sum_reg + 64'(sq_reg);
                end
                if (cnt_reg == 6'd3) begin
                    rad_reg  <= sum_reg + 64'(sq_reg);
                    root_reg <= '0;
                    bit_reg  <= 64'd1 << 62;
                    cnt_reg  <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            NS_SQRT: begin
                if (rad_reg >= sq_trial) begin
                    rad_reg  <= rad_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == 6'd31) begin
                    cnt_reg  <= '0;
                    idx_reg  <= '0;
                    dvd_reg  <= {mag_reg[0][30:0], 29'd0};
                    drem_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            NS_DIV: begin
                drem_reg <= qbit ? 32'(dtrial - {1'b0, root_reg[31:0]}) : dtrial[31:0];
                dvd_reg  <= dvd_reg << 1;
                quo_reg  <= qfin;
                if (cnt_reg == 6'd59) begin
                    u_reg[idx_reg] <= neg_reg[idx_reg] ? -$signed({1'b0, qfin})
                                                       :  $signed({1'b0, qfin});
                    idx_reg  <= idx_reg + 2'd1;
                    cnt_reg  <= '0;
                    drem_reg <= '0;
                    dvd_reg  <= {div_src, 29'd0};
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign res.done = (state_reg == NS_DONE);
    assign res.deg  = deg_reg;
    assign res.ux   = deg_reg ? '0 : u_reg[0];
    assign res.uy   = deg_reg ? '0 : u_reg[1];
    assign res.uz   = deg_reg ? '0 : u_reg[2];

endmodule

`default_nettype wire

// ----- rtl/core/bounding_box_depth_range.sv -----
// ----------------------------------------------------------------------------
// bounding_box_depth_range
// Near/far clip depths of an axis-aligned box seen along the eye-to-target
// direction, signed Q16.16 in and out.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                    beat when
//  s_axis    in    six box bounds, 192b tdata                 s_tvalid & s_tready
//  m_axis    out   near(31b) far(32b) in tdata, flag in tuser m_tvalid & m_tready
//  cfg       in    3b register index, 32b data                cfg_valid & cfg_ready
//
//  One box per cycle while s_tready is high (no m_tready stall, direction
//  unit done); nine register stages, the last driving the m_axis outputs.
//  After reset and after any config write the direction unit (shift search,
//  squares, bit-serial sqrt, three bit-serial divides) recomputes, and
//  s_tready stays low meanwhile. cfg_ready is always high.
//  Stalls on m_tready back up stage by stage; bubbles are squeezed out.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_box_depth_range (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // x_lo, x_hi, y_lo, y_hi, z_lo, z_hi (32b each, low bits first)
    input  wire logic [191:0]          s_tdata,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // near_depth [30:0], far_depth [62:31], zero [63]
    output      logic [63:0]           m_tdata,
    // used_default [0]
    output      logic [0:0]            m_tuser,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [bbdr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [bbdr_pkg::COORD_W-1:0] cfg_data
);
    import bbdr_pkg::*;

    localparam int NST = 9;

    // configuration registers
    logic [2:0][COORD_W-1:0] eye_reg;
    logic [2:0][COORD_W-1:0] tgt_reg;
    logic                    cfg_wr;
    norm_res_t               norm;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eye_reg <= {EYE_Z_RESET, 32'd0, 32'd0};
            tgt_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_reg_t'(cfg_index))
                REG_EYE_X:    eye_reg[0] <= cfg_data;
                REG_EYE_Y:    eye_reg[1] <= cfg_data;
                REG_EYE_Z:    eye_reg[2] <= cfg_data;
                REG_TARGET_X: tgt_reg[0] <= cfg_data;
                REG_TARGET_Y: tgt_reg[1] <= cfg_data;
                REG_TARGET_Z: tgt_reg[2] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    bbdr_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_wr),
        .eye_pos (eye_reg),
        .tgt_pos (tgt_reg),
        .res     (norm)
    );

    // stage handshake: stage k loads when empty or when k+1 loads
    logic v_reg [1:NST];
    logic en    [1:NST];

    always_comb begin
        en[NST] = !v_reg[NST] || m_tready;
        for (int k = NST - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1] && norm.done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= NST; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else begin
            if (en[1]) v_reg[1] <= s_tvalid && norm.done;
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // S1: corner offsets from eye, per bound (x lo/hi, y lo/hi, z lo/hi)
    logic signed [32:0] p1_reg [6];
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int j = 0; j < 6; j++) begin
                p1_reg[j] <= $signed({s_tdata[32*j+31], s_tdata[32*j +: 32]})
                           - $signed({eye_reg[j/2][31], eye_reg[j/2]});
            end
        end
    end

    // S2: projections of each bound on its axis of the unit vector
    logic signed [63:0] pr2_reg [6];
    logic signed [UNIT_W-1:0] u_ax [3];
    assign u_ax[0] = norm.ux;
    assign u_ax[1] = norm.uy;
    assign u_ax[2] = norm.uz;
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int j = 0; j < 6; j++) begin
                pr2_reg[j] <= 64'(p1_reg[j]) * 64'(u_ax[j/2]);
            end
        end
    end

    // S3: corner sum is separable, so min/max per axis
    logic signed [63:0] mn3_reg [3];
    logic signed [63:0] mx3_reg [3];
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int a = 0; a < 3; a++) begin
                if (pr2_reg[2*a] < pr2_reg[2*a+1]) begin
                    mn3_reg[a] <= pr2_reg[2*a];
                    mx3_reg[a] <= pr2_reg[2*a+1];
                end else begin
                    mn3_reg[a] <= pr2_reg[2*a+1];
                    mx3_reg[a] <= pr2_reg[2*a];
                end
            end
        end
    end

    // S4: sum, floor shift to Q16.16, pre-clamp to what can change results
    logic signed [65:0] smin, smax;
    logic signed [36:0] dmin, dmax;
    logic [31:0]        nv4_next;
    logic signed [31:0] fv4_next;
    logic [31:0]        nv4_reg;
    logic signed [31:0] fv4_reg;
    logic               deg4_reg;

    always_comb begin
        smin = 66'(mn3_reg[0]) + 66'(mn3_reg[1]) + 66'(mn3_reg[2]);
        smax = 66'(mx3_reg[0]) + 66'(mx3_reg[1]) + 66'(mx3_reg[2]);
        dmin = smin[65:UNIT_BITS];
        dmax = smax[65:UNIT_BITS];
        // negative min always lands on 1.0; above 2^32-1 always saturates
        if (dmin[36]) begin
            nv4_next = '0;
        end else if (|dmin[35:32]) begin
            nv4_next = '1;
        end else begin
            nv4_next = dmin[31:0];
        end
        if (dmax[36:31] == 6'b000000 || dmax[36:31] == 6'b111111) begin
            fv4_next = dmax[31:0];
        end else if (dmax[36]) begin
            fv4_next = 32'sh8000_0000;
        end else begin
            fv4_next = 32'sh7FFF_FFFF;
        end
        if (norm.deg) begin
            nv4_next = DEF_MIN_DEP;
            fv4_next = DEF_MAX_DEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            nv4_reg  <= nv4_next;
            fv4_reg  <= fv4_next;
            deg4_reg <= norm.deg;
        end
    end

    // S5: scale by 9 / 11, fold sign so lane divides a magnitude
    // lane 0 near, lane 1 far
    logic signed [35:0] fm;
    logic [35:0]        a5_reg [2];
    logic               neg5_reg, deg5_reg;
    assign fm = 36'(fv4_reg) * 36'sd11;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            a5_reg[0] <= {4'd0, nv4_reg} * 36'd9;
            a5_reg[1] <= fm[35] ? (36'd0 - $unsigned(fm)) + 36'd9 : $unsigned(fm);
            neg5_reg  <= fm[35];
            deg5_reg  <= deg4_reg;
        end
    end

    // S6..S8: divide by 10 in two 18-bit halves
    logic [39:0] ph [2];
    logic [14:0] qh6_reg [2];
    logic [35:0] a6_reg  [2];
    logic        neg6_reg, deg6_reg;
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            ph[l] = 40'(a5_reg[l][35:18]) * 40'(RECIP10);
        end
    end
    always_ff @(posedge aclk) begin
        if (en[6]) begin
            for (int l = 0; l < 2; l++) begin
                qh6_reg[l] <= ph[l][39:RECIP_SH];
                a6_reg[l]  <= a5_reg[l];
            end
            neg6_reg <= neg5_reg;
            deg6_reg <= deg5_reg;
        end
    end

    logic [17:0] rh [2];
    logic [21:0] x7_reg  [2];
    logic [14:0] qh7_reg [2];
    logic        neg7_reg, deg7_reg;
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rh[l] = a6_reg[l][35:18] - 18'(qh6_reg[l]) * 18'd10;
        end
    end
    always_ff @(posedge aclk) begin
        if (en[7]) begin
            for (int l = 0; l < 2; l++) begin
                x7_reg[l]  <= {rh[l][3:0], a6_reg[l][17:0]};
                qh7_reg[l] <= qh6_reg[l];
            end
            neg7_reg <= neg6_reg;
            deg7_reg <= deg6_reg;
        end
    end

    logic [43:0] pl [2];
    logic [18:0] ql8_reg [2];
    logic [14:0] qh8_reg [2];
    logic        neg8_reg, deg8_reg;
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            pl[l] = 44'(x7_reg[l]) * 44'(RECIP10);
        end
    end
    always_ff @(posedge aclk) begin
        if (en[8]) begin
            for (int l = 0; l < 2; l++) begin
                ql8_reg[l] <= pl[l][43:RECIP_SH];
                qh8_reg[l] <= qh7_reg[l];
            end
            neg8_reg <= neg7_reg;
            deg8_reg <= deg7_reg;
        end
    end

    // S9: join quotient halves, final clamps; output register
    logic [33:0]        qn, qf;
    logic [30:0]        near_next;
    logic signed [31:0] far_next;
    logic [30:0]        near_reg;
    logic [31:0]        far_reg;
    logic               deg9_reg;

    always_comb begin
        qn = {qh8_reg[0], 18'd0} + 34'(ql8_reg[0]);
        qf = {qh8_reg[1], 18'd0} + 34'(ql8_reg[1]);
        if (qn < 34'(NEAR_MIN)) begin
            near_next = NEAR_MIN;
        end else if (qn > 34'(NEAR_MAX)) begin
            near_next = NEAR_MAX;
        end else begin
            near_next = qn[30:0];
        end
        if (neg8_reg) begin
            far_next = (qf > 34'h0_8000_0000) ? 32'sh8000_0000 : -$signed(qf[31:0]);
        end else begin
            far_next = (qf > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qf[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            near_reg <= near_next;
            far_reg  <= far_next;
            deg9_reg <= deg8_reg;
        end
    end

    assign m_tvalid = v_reg[NST];
    assign m_tdata  = {1'b0, far_reg, near_reg};
    assign m_tuser  = deg9_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bbdr_chk.sv -----
// ----------------------------------------------------------------------------
// bbdr_chk
// Port-level checks for the bounding box depth range block.
// ----------------------------------------------------------------------------
`default_nettype none

module bbdr_chk (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic [191:0] s_tdata,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [0:0]   m_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [2:0]   cfg_index,
    input wire logic [31:0]  cfg_data
);

    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_near_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:0] >= 31'h0001_0000)
        else $error("near below 1.0");

    a_default: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[30:0] == 31'h0001_0000 && m_tdata[62:31] == 32'h000B_0000)
        else $error("default depths wrong");

    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input taken while direction recomputes");

endmodule

bind bounding_box_depth_range bbdr_chk u_bbdr_chk (.*);

`default_nettype wire
